[src/winch_motor_limit_controller_top_macros.svh]
// ----------------------------------------------------------------------------
// Winch motor limit controller assertion macros
// Short forms for the concurrent checks of the top level. They expect
// clk_i and rst_ni in the scope of the use.
// ----------------------------------------------------------------------------
`ifndef WINCH_MOTOR_LIMIT_CONTROLLER_TOP_MACROS_SVH
`define WINCH_MOTOR_LIMIT_CONTROLLER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WMLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/wmlc_pkg.sv]
// ----------------------------------------------------------------------------
// Winch motor limit controller package
// Shared types, codes and constants of the winch motor supervisor.
// ----------------------------------------------------------------------------
package wmlc_pkg;

  // Fixed limits of the winch.
  localparam logic [12:0] DRIVE_SPEED_CAP = 13'd400;
  localparam logic [12:0] POSITION_TOP    = 13'd4096;
  localparam logic [12:0] POS_SAT         = 13'h1FFF;
  localparam logic [10:0] CNT_SAT         = 11'h7FF;

  // Reset values of the configuration registers.
  localparam logic [12:0] MIN_POS_RST  = 13'd1;
  localparam logic [12:0] MAX_POS_RST  = 13'd4096;
  localparam logic [10:0] TOP_DB_RST   = 11'd20;
  localparam logic [10:0] SLACK_DB_RST = 11'd550;

  // Reset position of the encoder count.
  localparam logic [12:0] POS_RST = 13'd1;

  typedef enum logic [2:0] {
    MODE_DOWN      = 3'd0,
    MODE_UP        = 3'd1,
    MODE_TO_TARGET = 3'd2,
    MODE_AT_TARGET = 3'd3,
    MODE_TOP       = 3'd4,
    MODE_SLACK     = 3'd5,
    MODE_MIN       = 3'd6,
    MODE_MAX       = 3'd7
  } wmlc_mode_e;

  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_SET_SPEED  = 3'd1,
    CMD_SET_DIR    = 3'd2,
    CMD_SET_TARGET = 3'd3,
    CMD_GO_TARGET  = 3'd4,
    CMD_SET_POS    = 3'd5
  } wmlc_cmd_e;

  typedef enum logic [1:0] {
    REG_MIN_POS  = 2'd0,
    REG_MAX_POS  = 2'd1,
    REG_TOP_DB   = 2'd2,
    REG_SLACK_DB = 2'd3
  } wmlc_reg_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [12:0] cmd_value;
    logic        encoder_edge;
    logic        ms_tick;
    logic        top_raw;
    logic        slack_raw;
  } wmlc_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [8:0]  drive_speed;
    logic        drive_direction;
    logic [12:0] current_position;
    logic        mode_changed;
  } wmlc_result_t;

  typedef struct packed {
    logic [12:0] min_pos;
    logic [12:0] max_pos;
    logic [10:0] top_db;
    logic [10:0] slack_db;
  } wmlc_cfg_t;

  // Debounced sensor events of one transaction.
  typedef struct packed {
    logic top_chg;
    logic slack_chg;
  } wmlc_sense_t;

endpackage

[src/wmlc_debounce.sv]
// ----------------------------------------------------------------------------
// Sensor debouncer
// Counts steady milliseconds of one raw sensor level and flags the
// transaction in which a new level is accepted.
// ----------------------------------------------------------------------------
module wmlc_debounce import wmlc_pkg::*; #(
  parameter logic RESET_LEVEL = 1'b0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        raw_i,
  input  logic        tick_i,
  input  logic [10:0] lim_i,
  output logic        changed_o
);

  logic        last_q, last_d;
  logic        stable_q, stable_d;
  logic [10:0] cnt_q, cnt_d;

  // A level change restarts the count; a tick advances it up to saturation.
  always_comb begin
    if (raw_i != last_q) begin
      cnt_d = '0;
    end else if (tick_i && (cnt_q != CNT_SAT)) begin
      cnt_d = cnt_q + 11'd1;
    end else begin
      cnt_d = cnt_q;
    end
    last_d    = raw_i;
    changed_o = (cnt_d > lim_i) && (raw_i != stable_q);
    stable_d  = changed_o ? raw_i : stable_q;
  end

  // Sensor state, updated once per processed transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= RESET_LEVEL;
      stable_q <= RESET_LEVEL;
      cnt_q    <= '0;
    end else if (en_i) begin
      last_q   <= last_d;
      stable_q <= stable_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[src/wmlc_core.sv]
// ----------------------------------------------------------------------------
// Winch supervisor core
// Encoder count, command handling, sensor reactions and travel limits for
// one transaction, with the motor state registers.
// ----------------------------------------------------------------------------
module wmlc_core import wmlc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  wmlc_item_t   item_i,
  input  wmlc_cfg_t    cfg_i,
  input  wmlc_sense_t  sense_i,
  output wmlc_result_t result_o
);

  logic [12:0] pos_q, tgt_q;
  logic        dir_q;
  wmlc_mode_e  mode_q;
  logic [8:0]  spd_q;

  logic [12:0] pos, tgt, lo, hi;
  logic        dir, notif, reached;
  wmlc_mode_e  mode;
  logic [8:0]  spd;

  function automatic logic [12:0] clamp_lim(logic [12:0] v, logic [12:0] l, logic [12:0] h);
    logic [12:0] r;
    if (v < l) begin
      r = l;
    end else if (v > h) begin
      r = h;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic wmlc_mode_e follow_mode(logic d);
    return d ? MODE_UP : MODE_DOWN;
  endfunction

  function automatic logic blocked(wmlc_mode_e m, logic d);
    return ((m == MODE_MIN || m == MODE_TOP) && d) ||
           ((m == MODE_MAX || m == MODE_SLACK) && !d);
  endfunction

  function automatic logic [8:0] cap_speed(logic [12:0] v);
    logic [12:0] c;
    c = (v > DRIVE_SPEED_CAP) ? DRIVE_SPEED_CAP : v;
    return c[8:0];
  endfunction

  // Effective travel limits.
  assign lo = (cfg_i.min_pos == '0) ? 13'd1 : cfg_i.min_pos;
  assign hi = (cfg_i.max_pos > POSITION_TOP) ? POSITION_TOP : cfg_i.max_pos;

  // One pass over the transaction: encoder, command, sensors, limits.
  always_comb begin
    pos     = pos_q;
    tgt     = tgt_q;
    dir     = dir_q;
    mode    = mode_q;
    spd     = spd_q;
    notif   = 1'b0;
    reached = 1'b0;

    // Encoder edge moves the count, held at both ends.
    if (item_i.encoder_edge) begin
      if (!dir) begin
        if (pos != POS_SAT) pos = pos + 13'd1;
      end else begin
        if (pos != '0) pos = pos - 13'd1;
      end
    end

    // Command.
    case (wmlc_cmd_e'(item_i.cmd))
      CMD_SET_SPEED: begin
        if (item_i.cmd_value == '0) begin
          spd = '0;
        end else if (!blocked(mode, dir)) begin
          spd = cap_speed(item_i.cmd_value);
        end
      end
      CMD_SET_DIR: begin
        if (dir != item_i.cmd_value[0]) begin
          dir = item_i.cmd_value[0];
          if (mode != follow_mode(dir)) begin
            mode  = follow_mode(dir);
            notif = 1'b1;
          end
        end
      end
      CMD_SET_TARGET: begin
        if (item_i.cmd_value == '0) begin
          tgt = '0;
        end else begin
          tgt = clamp_lim(item_i.cmd_value, lo, hi);
          if ((!dir && pos > tgt) || (dir && pos < tgt)) begin
            dir = !dir;
            if (mode != follow_mode(dir)) begin
              mode  = follow_mode(dir);
              notif = 1'b1;
            end
          end
        end
      end
      CMD_GO_TARGET: begin
        if (item_i.cmd_value != '0) begin
          // Travel to target is never a blocked mode, so the speed is taken.
          if (tgt != '0) begin
            mode  = MODE_TO_TARGET;
            notif = 1'b1;
            spd   = cap_speed(item_i.cmd_value);
          end
        end else if (mode != follow_mode(dir)) begin
          mode  = follow_mode(dir);
          notif = 1'b1;
        end
      end
      CMD_SET_POS: begin
        pos = clamp_lim(item_i.cmd_value, lo, hi);
      end
      default: begin
      end
    endcase

    // Top sensor: arriving stops and presets, leaving resumes.
    if (sense_i.top_chg) begin
      if (!item_i.top_raw) begin
        spd   = '0;
        mode  = MODE_TOP;
        pos   = clamp_lim(13'd1, lo, hi);
        notif = 1'b1;
      end else if (mode != follow_mode(dir)) begin
        mode  = follow_mode(dir);
        notif = 1'b1;
      end
    end

    // Slack sensor: slack stops, recovery resumes.
    if (sense_i.slack_chg) begin
      if (item_i.slack_raw) begin
        spd   = '0;
        mode  = MODE_SLACK;
        notif = 1'b1;
      end else if (mode != follow_mode(dir)) begin
        mode  = follow_mode(dir);
        notif = 1'b1;
      end
    end

    // Travel limits and target arrival.
    if (mode != MODE_TOP && mode != MODE_SLACK) begin
      if (pos < lo) begin
        if (mode != MODE_MIN) begin
          spd   = '0;
          mode  = MODE_MIN;
          notif = 1'b1;
        end
      end else if (pos > hi) begin
        if (mode != MODE_MAX) begin
          spd   = '0;
          mode  = MODE_MAX;
          notif = 1'b1;
        end
      end else begin
        reached = (tgt != '0) && (dir ? (pos < tgt) : (pos > tgt));
        if (reached) begin
          if (mode != MODE_AT_TARGET) begin
            spd   = '0;
            tgt   = '0;
            mode  = MODE_AT_TARGET;
            notif = 1'b1;
          end
        end else if (mode != MODE_TO_TARGET && mode != follow_mode(dir)) begin
          mode  = follow_mode(dir);
          notif = 1'b1;
        end
      end
    end

    result_o.mode             = mode;
    result_o.drive_speed      = spd;
    result_o.drive_direction  = dir;
    result_o.current_position = pos;
    result_o.mode_changed     = notif;
  end

  // Motor state, updated once per processed transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_RST;
      tgt_q  <= '0;
      dir_q  <= 1'b0;
      mode_q <= MODE_DOWN;
      spd_q  <= '0;
    end else if (en_i) begin
      pos_q  <= pos;
      tgt_q  <= tgt;
      dir_q  <= dir;
      mode_q <= mode;
      spd_q  <= spd;
    end
  end

endmodule

[src/winch_motor_limit_controller_top.sv]
// ----------------------------------------------------------------------------
// Winch motor limit controller
// Supervises a winch motor from encoder edges, commands and two debounced
// sensors, and reports mode, drive and position for every transaction.
//
//   Channel   Handshake                    Payload
//   item      item_valid_i / item_ready_o  item_i  (wmlc_item_t)
//   result    res_valid_o  / res_ready_i   res_o   (wmlc_result_t)
//   config    cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle while the result register is free or taken;
// an accepted transaction passes the input register and then the result
// register. The supervisor state is updated in the single cycle that moves a
// transaction from the input register to the result register.
// Reset returns state, configuration and valid flags to their defaults,
// not the payload registers. A stalled result holds both stages; the input
// is refused only when both stages are full and the result is not taken.
// ----------------------------------------------------------------------------
`include "winch_motor_limit_controller_top_macros.svh"

module winch_motor_limit_controller_top import wmlc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_valid_i,
  output logic         item_ready_o,
  input  wmlc_item_t   item_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output wmlc_result_t res_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [12:0]  cfg_wdata_i
);

  wmlc_cfg_t    cfg_q;
  wmlc_item_t   in_q;
  logic         in_valid_q;
  wmlc_result_t res_q, res_d;
  logic         res_valid_q;
  logic         advance;
  wmlc_sense_t  sense;
  logic         top_hit, res_stopped, speed_ok;

  // Pipeline control: a stage advances when the result register is free or taken.
  assign advance      = in_valid_q && (!res_valid_q || res_ready_i);
  assign item_ready_o = !in_valid_q || advance;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pos  <= MIN_POS_RST;
      cfg_q.max_pos  <= MAX_POS_RST;
      cfg_q.top_db   <= TOP_DB_RST;
      cfg_q.slack_db <= SLACK_DB_RST;
    end else if (cfg_we_i) begin
      case (wmlc_reg_e'(cfg_idx_i))
        REG_MIN_POS:  cfg_q.min_pos  <= cfg_wdata_i;
        REG_MAX_POS:  cfg_q.max_pos  <= cfg_wdata_i;
        REG_TOP_DB:   cfg_q.top_db   <= cfg_wdata_i[10:0];
        REG_SLACK_DB: cfg_q.slack_db <= cfg_wdata_i[10:0];
        default: begin
        end
      endcase
    end
  end

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_ready_o) begin
      in_valid_q <= item_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (item_valid_i && item_ready_o) begin
      in_q <= item_i;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Top sensor debouncer; the sensor rests out at reset.
  wmlc_debounce #(
    .RESET_LEVEL (1'b1)
  ) u_top_db (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .raw_i     (in_q.top_raw),
    .tick_i    (in_q.ms_tick),
    .lim_i     (cfg_q.top_db),
    .changed_o (sense.top_chg)
  );

  // Slack sensor debouncer; no slack at reset.
  wmlc_debounce #(
    .RESET_LEVEL (1'b0)
  ) u_slack_db (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .raw_i     (in_q.slack_raw),
    .tick_i    (in_q.ms_tick),
    .lim_i     (cfg_q.slack_db),
    .changed_o (sense.slack_chg)
  );

  // Supervisor core.
  wmlc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .sense_i  (sense),
    .result_o (res_d)
  );

  // Terms of the checks below.
  assign top_hit     = advance && sense.top_chg && !in_q.top_raw;
  assign res_stopped = (res_o.drive_speed == '0) &&
                       (res_o.mode == MODE_TOP || res_o.mode == MODE_SLACK);
  assign speed_ok    = {4'b0000, res_o.drive_speed} <= DRIVE_SPEED_CAP;

  // An empty input stage always takes a new transaction.
  `WMLC_ASSERT_NOW(a_ready_when_empty, !in_valid_q, item_ready_o, "empty input not ready")

  // A debounced top hit leaves the motor stopped in a sensor mode.
  `WMLC_ASSERT_NEXT(a_top_hit_stops, top_hit, res_stopped, "top hit did not stop the motor")

  // The driven speed never exceeds the cap.
  `WMLC_ASSERT_NOW(a_speed_cap, res_valid_o, speed_ok, "drive speed above cap")

endmodule

[tb/winch_motor_limit_controller_top_tb.sv]
// ----------------------------------------------------------------------------
// Winch motor limit controller testbench
// Drives item transactions into the supervisor and checks each result
// transaction against a cycle-free prediction of mode, drive and position.
// A directed opening covers the command set and the limit corner cases. A
// short descent then passes the maximum, and the top sensor is debounced at
// its reset setting. Random phases under several register settings follow,
// with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module winch_motor_limit_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wmlc_pkg::*;

  // Command codes that the block must ignore.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC
  } ready_style_e;

  // Scoreboard: tracks the supervisor state and holds the awaited results.
  class winch_scoreboard;
    logic [12:0]  min_pos, max_pos;
    logic [10:0]  top_db, slack_db;
    logic [12:0]  position, target;
    logic         direction;
    wmlc_mode_e   mode;
    logic [8:0]   speed;
    logic         top_stable, top_last, slack_stable, slack_last;
    logic [10:0]  top_ms, slack_ms;
    bit           notified;
    wmlc_result_t awaited_q[$];
    int unsigned  fail_count;

    function new();
      min_pos      = MIN_POS_RST;
      max_pos      = MAX_POS_RST;
      top_db       = TOP_DB_RST;
      slack_db     = SLACK_DB_RST;
      position     = POS_RST;
      target       = '0;
      direction    = 1'b0;
      mode         = MODE_DOWN;
      speed        = '0;
      top_stable   = 1'b1;
      top_last     = 1'b1;
      top_ms       = '0;
      slack_stable = 1'b0;
      slack_last   = 1'b0;
      slack_ms     = '0;
      fail_count   = 0;
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction

    function void write_reg(wmlc_reg_e idx, logic [12:0] value);
      case (idx)
        REG_MIN_POS:  min_pos  = value;
        REG_MAX_POS:  max_pos  = value;
        REG_TOP_DB:   top_db   = value[10:0];
        REG_SLACK_DB: slack_db = value[10:0];
        default: ;
      endcase
    endfunction

    // Effective limits: a zero minimum acts as one, the maximum caps at the top.
    function logic [12:0] lo_lim();
      return (min_pos < 13'd1) ? 13'd1 : min_pos;
    endfunction

    function logic [12:0] hi_lim();
      return (max_pos > POSITION_TOP) ? POSITION_TOP : max_pos;
    endfunction

    function logic [12:0] clamp_pos(logic [12:0] value);
      if (value < lo_lim()) return lo_lim();
      if (value > hi_lim()) return hi_lim();
      return value;
    endfunction

    function void enter_mode(wmlc_mode_e m);
      if (mode != m) begin
        mode     = m;
        notified = 1'b1;
      end
    endfunction

    function void follow_dir();
      enter_mode(direction ? MODE_UP : MODE_DOWN);
    endfunction

    function void block_mode(wmlc_mode_e m);
      if (mode != m) begin
        speed    = '0;
        mode     = m;
        notified = 1'b1;
      end
    endfunction

    function bit dir_blocked();
      if (mode == MODE_MIN || mode == MODE_TOP) return direction == 1'b1;
      if (mode == MODE_MAX || mode == MODE_SLACK) return direction == 1'b0;
      return 1'b0;
    endfunction

    // A nonzero speed is capped and refused while the direction is blocked.
    function void apply_speed(logic [12:0] s);
      if (s == '0) speed = '0;
      else if (!dir_blocked()) speed = (s > DRIVE_SPEED_CAP) ? 9'(DRIVE_SPEED_CAP) : s[8:0];
    endfunction

    function void turn(logic d);
      if (direction != d) begin
        direction = d;
        follow_dir();
      end
    endfunction

    // One debounce step; true once the level has been steady long enough.
    function bit settle(input logic raw, input logic tick, input logic [10:0] lim,
                        inout logic last, inout logic [10:0] cnt);
      if (raw != last) cnt = '0;
      else if (tick && cnt != CNT_SAT) cnt = cnt + 11'd1;
      last = raw;
      return cnt > lim;
    endfunction

    // Advance the predicted state by one accepted item and queue its result.
    function void note_item(wmlc_item_t it);
      bit           top_ok, slack_ok, reached;
      wmlc_result_t res;
      notified = 1'b0;

      // The encoder edge comes first.
      if (it.encoder_edge) begin
        if (!direction) begin
          if (position != POS_SAT) position = position + 13'd1;
        end else if (position != '0) begin
          position = position - 13'd1;
        end
      end

      // Then the command.
      case (it.cmd)
        CMD_SET_SPEED: apply_speed(it.cmd_value);
        CMD_SET_DIR:   turn(it.cmd_value[0]);
        CMD_SET_TARGET: begin
          if (it.cmd_value == '0) begin
            target = '0;
          end else begin
            target = clamp_pos(it.cmd_value);
            if (!direction) begin
              if (position > target) turn(1'b1);
            end else if (position < target) begin
              turn(1'b0);
            end
          end
        end
        CMD_GO_TARGET: begin
          if (it.cmd_value != '0) begin
            if (target != '0) begin
              mode     = MODE_TO_TARGET;
              notified = 1'b1;
              apply_speed(it.cmd_value);
            end
          end else begin
            follow_dir();
          end
        end
        CMD_SET_POS: position = clamp_pos(it.cmd_value);
        default: ;
      endcase

      // Debounced sensors.
      top_ok = settle(it.top_raw, it.ms_tick, top_db, top_last, top_ms);
      if (top_ok && it.top_raw != top_stable) begin
        top_stable = it.top_raw;
        if (!it.top_raw) begin
          speed    = '0;
          mode     = MODE_TOP;
          position = clamp_pos(13'd1);
          notified = 1'b1;
        end else begin
          follow_dir();
        end
      end
      slack_ok = settle(it.slack_raw, it.ms_tick, slack_db, slack_last, slack_ms);
      if (slack_ok && it.slack_raw != slack_stable) begin
        slack_stable = it.slack_raw;
        if (!it.slack_raw) begin
          follow_dir();
        end else begin
          speed    = '0;
          mode     = MODE_SLACK;
          notified = 1'b1;
        end
      end

      // Position limits and the target.
      if (mode != MODE_TOP && mode != MODE_SLACK) begin
        if (position < lo_lim()) begin
          block_mode(MODE_MIN);
        end else if (position > hi_lim()) begin
          block_mode(MODE_MAX);
        end else begin
          reached = (target != '0) &&
                    (direction ? (position < target) : (position > target));
          if (reached) begin
            if (mode != MODE_AT_TARGET) begin
              speed    = '0;
              target   = '0;
              mode     = MODE_AT_TARGET;
              notified = 1'b1;
            end
          end else if (mode != MODE_TO_TARGET) begin
            follow_dir();
          end
        end
      end

      res.mode             = mode;
      res.drive_speed      = speed;
      res.drive_direction  = direction;
      res.current_position = position;
      res.mode_changed     = notified;
      awaited_q.push_back(res);
    endfunction

    function void check_field(string name, logic [12:0] want, logic [12:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fail_count++;
      end
    endfunction

    // Compare a result with the oldest awaited one.
    function void check_result(wmlc_result_t got);
      wmlc_result_t want;
      if (awaited_q.size() == 0) begin
        $error("result with none awaited: mode %0d position %0d",
               got.mode, got.current_position);
        fail_count++;
      end else begin
        want = awaited_q.pop_front();
        check_field("mode", want.mode, got.mode);
        check_field("drive_speed", want.drive_speed, got.drive_speed);
        check_field("drive_direction", want.drive_direction, got.drive_direction);
        check_field("current_position", want.current_position, got.current_position);
        check_field("mode_changed", want.mode_changed, got.mode_changed);
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         item_valid_i;
  logic         item_ready_o;
  wmlc_item_t   item_i;
  logic         res_valid_o;
  logic         res_ready_i;
  wmlc_result_t res_o;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [12:0]  cfg_wdata_i;

  winch_scoreboard sb = new();

  int unsigned  burst_left = 0;
  int unsigned  gap_max = 4;
  ready_style_e ready_style = READY_RANDOM;
  int unsigned  ready_tick = 0;
  logic         top_hold = 1'b1;
  logic         slack_hold = 1'b0;

  winch_motor_limit_controller_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_i),
    .item_ready_o (item_ready_o),
    .item_i       (item_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .res_o        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Result receiver: stalls according to the style of the current phase.
  always @(posedge clk_i) begin
    ready_tick <= ready_tick + 1;
    case (ready_style)
      READY_ALWAYS:   res_ready_i <= 1'b1;
      READY_RANDOM:   res_ready_i <= ($urandom_range(0, 99) < 65);
      READY_PERIODIC: res_ready_i <= ((ready_tick % 9) < 5);
      default:        res_ready_i <= 1'b1;
    endcase
  end

  // Transaction monitor for both channels.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_valid_i && item_ready_o) sb.note_item(item_i);
      if (res_valid_o && res_ready_i) sb.check_result(res_o);
    end
  end

  // Watchdog on the total run length.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic wmlc_item_t make_item(logic [2:0] cmd, logic [12:0] value,
                                           logic enc, logic tick, logic top,
                                           logic slack);
    wmlc_item_t it;
    it.cmd          = cmd;
    it.cmd_value    = value;
    it.encoder_edge = enc;
    it.ms_tick      = tick;
    it.top_raw      = top;
    it.slack_raw    = slack;
    return it;
  endfunction

  // Random item: sensors held at slowly changing levels with rare glitches,
  // targets mostly aimed close to the present position.
  function automatic wmlc_item_t random_item();
    wmlc_item_t  it;
    int unsigned roll, pick;
    int          near_pos;
    if ($urandom_range(0, 59) == 0) top_hold = ~top_hold;
    if ($urandom_range(0, 59) == 0) slack_hold = ~slack_hold;
    it.encoder_edge = ($urandom_range(0, 9) < 7);
    it.ms_tick      = $urandom_range(0, 1);
    it.top_raw      = ($urandom_range(0, 39) == 0) ? ~top_hold : top_hold;
    it.slack_raw    = ($urandom_range(0, 39) == 0) ? ~slack_hold : slack_hold;
    it.cmd_value    = 13'($urandom);
    roll            = $urandom_range(0, 99);
    pick            = $urandom_range(0, 9);
    near_pos        = int'(sb.position) + int'($urandom_range(0, 60)) - 30;
    if (near_pos < 1) near_pos = 1;
    if (near_pos > 8191) near_pos = 8191;
    if (roll < 45) begin
      it.cmd = CMD_NONE;
    end else if (roll < 57) begin
      it.cmd = CMD_SET_SPEED;
      if (pick < 8) it.cmd_value = 13'($urandom_range(0, 450));
    end else if (roll < 64) begin
      it.cmd = CMD_SET_DIR;
    end else if (roll < 76) begin
      it.cmd = CMD_SET_TARGET;
      if (pick < 7) it.cmd_value = 13'(near_pos);
      else if (pick < 8) it.cmd_value = '0;
    end else if (roll < 86) begin
      it.cmd = CMD_GO_TARGET;
      if (pick < 8) it.cmd_value = 13'($urandom_range(0, 450));
    end else if (roll < 93) begin
      it.cmd = CMD_SET_POS;
      if (pick < 7) it.cmd_value = 13'($urandom_range(sb.lo_lim(), sb.hi_lim()));
    end else begin
      it.cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
    end
    return it;
  endfunction

  // Present one item, opening a new burst after a random gap when due.
  task automatic send_item(input wmlc_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        item_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    item_valid_i <= 1'b1;
    item_i       <= it;
    do @(posedge clk_i); while (!item_ready_o);
  endtask

  // Hold the sender until every awaited result has been taken.
  task automatic drain();
    item_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_config(logic [12:0] min_v, logic [12:0] max_v,
                              logic [12:0] top_v, logic [12:0] slack_v);
    logic [12:0] vals [4];
    vals = '{min_v, max_v, top_v, slack_v};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= wmlc_reg_e'(2'(i));
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(wmlc_reg_e'(2'(i)), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic [12:0] min_v, logic [12:0] max_v, logic [12:0] top_v,
                           logic [12:0] slack_v, int unsigned n_items,
                           int unsigned gaps, ready_style_e style);
    drain();
    write_config(min_v, max_v, top_v, slack_v);
    gap_max     = gaps;
    ready_style = style;
    repeat (n_items) begin
      send_item(random_item());
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    item_valid_i = 1'b0;
    item_i       = '0;
    res_ready_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening under the reset register values.
    send_item(make_item(CMD_NONE, 13'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_SET_SPEED, 13'h1FFF, 1'b0, 1'b1, 1'b1, 1'b0));
    send_item(make_item(CMD_SET_SPEED, 13'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_SET_SPEED, 13'd123, 1'b0, 1'b0, 1'b1, 1'b0));
    // Turn up and run below the minimum, then push against the floor at zero.
    send_item(make_item(CMD_SET_DIR, 13'h1FFF, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_NONE, 13'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_SET_SPEED, 13'd200, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_NONE, 13'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_SET_DIR, 13'h1FFE, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_SET_POS, 13'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    // Target clamping, going to target and reaching it.
    send_item(make_item(CMD_SET_TARGET, 13'h1FFF, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_GO_TARGET, 13'h1FFF, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_SET_TARGET, 13'd3, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_NONE, 13'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_NONE, 13'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_NONE, 13'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_GO_TARGET, 13'd50, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_GO_TARGET, 13'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    // Beyond the maximum, a target behind turns the direction round.
    send_item(make_item(CMD_SET_POS, 13'd4096, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_NONE, 13'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_SET_TARGET, 13'd10, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_SET_POS, 13'h1FFF, 1'b0, 1'b0, 1'b1, 1'b0));
    // Unknown commands and a single-item sensor glitch.
    send_item(make_item(CMD_SPARE_A, 13'h1FFF, 1'b1, 1'b1, 1'b1, 1'b0));
    send_item(make_item(CMD_SPARE_B, 13'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_NONE, 13'd0, 1'b0, 1'b1, 1'b0, 1'b1));

    // Short descent: the count passes the maximum.
    send_item(make_item(CMD_SET_DIR, 13'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_SET_POS, 13'd4096, 1'b0, 1'b0, 1'b1, 1'b0));
    repeat (6) send_item(make_item(CMD_NONE, 13'd0, 1'b1, 1'b1, 1'b1, 1'b0));
    // Top sensor in and out at the reset debounce time.
    repeat (25) send_item(make_item(CMD_NONE, 13'd0, 1'b0, 1'b1, 1'b0, 1'b0));
    repeat (25) send_item(make_item(CMD_NONE, 13'd0, 1'b0, 1'b1, 1'b1, 1'b0));

    // Random phases under a range of register settings.
    run_phase(13'd1, 13'd4096, 13'd0, 13'd0, 70, 0, READY_ALWAYS);
    run_phase(13'd100, 13'd300, 13'd3, 13'd5, 80, 6, READY_RANDOM);
    run_phase(13'd0, 13'h1FFF, 13'd2047, 13'd2047, 60, 3, READY_PERIODIC);
    run_phase(13'd500, 13'd200, 13'd1, 13'd2, 70, 8, READY_RANDOM);
    run_phase(13'd4096, 13'd4096, 13'd2000, 13'd0, 60, 2, READY_ALWAYS);
    run_phase(13'd1, 13'd50, 13'd10, 13'd20, 70, 5, READY_PERIODIC);
    run_phase(13'h1FFF, 13'd0, 13'd5, 13'd5, 50, 4, READY_RANDOM);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
